// File: design/softmax_argmax_classifier_head_core_macros.svh
// Assertion macros shared by the softmax/argmax head RTL.
// Used by the files that carry concurrent checks; needs no other file.
`ifndef SOFTMAX_ARGMAX_CLASSIFIER_HEAD_CORE_MACROS_SVH
`define SOFTMAX_ARGMAX_CLASSIFIER_HEAD_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Consequent checked in the same cycle as the antecedent
`define SMAX_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smax assertion failed");
// Consequent checked in the cycle after the antecedent
`define SMAX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smax assertion failed");
`else
`define SMAX_ASSERT_SAME(label, clk, rst, ante, cons)
`define SMAX_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/smax_pkg.sv
// Package for the softmax/argmax head: widths, constants, state and link types,
// and the elaboration-time builder for the exponent fraction table. No dependencies.
`default_nettype none

package smax_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_CLASSES_DEFAULT     = 16;
   localparam int EXP_TABLE_DEPTH_DEFAULT = 256;

   // Field and datapath widths
   localparam int LOGIT_W     = 16;
   localparam int EXP_W       = 17;
   localparam int PROB_W      = 16;
   localparam int CLASS_OUT_W = 4;
   localparam int CSR_W       = 5;
   localparam int MAG_W       = 13;
   localparam int Y_W         = 30;
   localparam int FRAC_W      = 24;
   localparam int K_W         = Y_W - FRAC_W;
   localparam int QUOT_BITS   = 17;

   // Constants of the arithmetic
   localparam logic [CSR_W-1:0]        CLASS_COUNT_RESET = 5'd11;
   localparam logic [16:0]             LOG2E_Q16         = 17'd94548;
   localparam logic signed [LOGIT_W:0] EXP_CUTOFF        = -17'sd4096;

   typedef enum logic [2:0] {
      CTL_LOAD,
      CTL_EXP_READ,
      CTL_EXP_START,
      CTL_EXP_WAIT,
      CTL_DIV_READ,
      CTL_DIV_START,
      CTL_DIV_WAIT,
      CTL_EMIT
   } ctl_state_type;

   typedef enum logic [1:0] {
      EXP_IDLE,
      EXP_MUL,
      EXP_IDX,
      EXP_ROUND
   } exp_state_type;

   typedef struct packed {
      logic                      start;
      logic signed [LOGIT_W:0]   diff;
   } exp_req_type;

   typedef struct packed {
      logic             done;
      logic [EXP_W-1:0] value;
   } exp_rsp_type;

   typedef struct packed {
      logic             start;
      logic [EXP_W-1:0] dividend;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROB_W-1:0] quotient;
   } div_rsp_type;

   // Integer square root, bit-pair method
   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] bitv;
      x    = x_in;
      r    = 64'd0;
      bitv = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (x >= r + bitv) begin
            x = x - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // One table entry: 2^(-q / 2^32) in Q1.16, from the Q0.32 fraction q
   function automatic logic [EXP_W-1:0] exp_frac_value(input logic [63:0] q);
      logic [63:0] root;
      logic [63:0] v;
      logic [63:0] rounded;
      root = isqrt64(64'd1 << 63);
      v    = 64'd1 << 32;
      for (int b = 1; b <= 32; b++) begin
         if (b > 1) begin
            root = isqrt64(root << 32);
         end
         if (q[32-b]) begin
            v = (v * root + (64'd1 << 31)) >> 32;
         end
      end
      rounded = (v + 64'd32768) >> 16;
      return rounded[EXP_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: design/smax_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Uses smax_pkg for its default sizes.
`default_nettype none

module smax_ram #(
   parameter int WIDTH = smax_pkg::LOGIT_W,
   parameter int DEPTH = smax_pkg::MAX_CLASSES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/smax_exp_unit.sv
// Exponent unit: exp(d) for d <= 0 in Q8.8 as Q1.16, via a bit-serial multiply
// by log2(e), a fraction table and a rounded shift. Depends on smax_pkg.
`default_nettype none

module smax_exp_unit #(
   parameter int EXP_TABLE_DEPTH = smax_pkg::EXP_TABLE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  smax_pkg::exp_req_type  exp_req,
   output smax_pkg::exp_rsp_type  exp_rsp
);

   localparam int IDX_W     = $clog2(EXP_TABLE_DEPTH);
   localparam int DEPTH_W   = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int FRAC_W    = smax_pkg::FRAC_W;
   localparam int Y_W       = smax_pkg::Y_W;
   localparam int K_W       = smax_pkg::K_W;
   localparam int MAG_W     = smax_pkg::MAG_W;
   localparam int EXP_W     = smax_pkg::EXP_W;
   localparam int PROD_W    = FRAC_W + DEPTH_W;
   localparam int LOGIT_W_P = smax_pkg::LOGIT_W;

   smax_pkg::exp_state_type state_ff, state_in;
   logic [MAG_W-1:0] mplier_ff, mplier_in;
   logic [Y_W-1:0]   mcand_ff, mcand_in;
   logic [Y_W-1:0]   acc_ff, acc_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [EXP_W-1:0] e_ff, e_in;
   logic             done_ff, done_in;

   logic [PROD_W-1:0]  prod;
   logic [DEPTH_W-1:0] idx_full;
   logic [EXP_W-1:0]   rom_val;
   logic [EXP_W-1:0]   shifted;
   logic [EXP_W:0]     round_sum;
   logic [LOGIT_W_P:0] neg_diff;

   // Fraction table, built at elaboration
   logic [EXP_W-1:0] exp_rom [EXP_TABLE_DEPTH];
   for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_rom
      localparam logic [63:0] FRAC_Q =
         ((64'(gi) << 32) + 64'(EXP_TABLE_DEPTH / 2)) / EXP_TABLE_DEPTH;
      assign exp_rom[gi] = smax_pkg::exp_frac_value(FRAC_Q);
   end

   // Next state and datapath
   always_comb begin
      state_in  = state_ff;
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      idx_in    = idx_ff;
      k_in      = k_ff;
      e_in      = e_ff;
      done_in   = 1'b0;
      prod      = PROD_W'(acc_ff[FRAC_W-1:0]) * PROD_W'(EXP_TABLE_DEPTH)
                  + (PROD_W'(1) << (FRAC_W - 1));
      idx_full  = prod[PROD_W-1:FRAC_W];
      rom_val   = exp_rom[idx_ff];
      shifted   = rom_val >> (k_ff - 1'b1);
      round_sum = {1'b0, shifted} + 1'b1;
      neg_diff  = -exp_req.diff;
      case (state_ff)
         smax_pkg::EXP_IDLE: begin
            if (exp_req.start) begin
               if ($signed(exp_req.diff) < $signed(smax_pkg::EXP_CUTOFF)) begin
                  // far below the maximum: the term vanishes
                  e_in    = '0;
                  done_in = 1'b1;
               end else begin
                  mplier_in = neg_diff[MAG_W-1:0];
                  mcand_in  = Y_W'(smax_pkg::LOG2E_Q16);
                  acc_in    = '0;
                  state_in  = smax_pkg::EXP_MUL;
               end
            end
         end
         smax_pkg::EXP_MUL: begin
            // shift-add one multiplier bit per cycle, stop when none remain
            if (mplier_ff == '0) begin
               state_in = smax_pkg::EXP_IDX;
            end else begin
               acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
               mplier_in = mplier_ff >> 1;
               mcand_in  = mcand_ff << 1;
            end
         end
         smax_pkg::EXP_IDX: begin
            // round the fraction to a table index, wrap into the integer part
            if (idx_full >= DEPTH_W'(EXP_TABLE_DEPTH)) begin
               idx_in = '0;
               k_in   = acc_ff[Y_W-1:FRAC_W] + 1'b1;
            end else begin
               idx_in = idx_full[IDX_W-1:0];
               k_in   = acc_ff[Y_W-1:FRAC_W];
            end
            state_in = smax_pkg::EXP_ROUND;
         end
         smax_pkg::EXP_ROUND: begin
            // scale by 2^-k, rounded to nearest
            if (k_ff == '0) begin
               e_in = rom_val;
            end else begin
               e_in = round_sum[EXP_W:1];
            end
            done_in  = 1'b1;
            state_in = smax_pkg::EXP_IDLE;
         end
         default: begin
            state_in = smax_pkg::EXP_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smax_pkg::EXP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
      idx_ff    <= idx_in;
      k_ff      <= k_in;
      e_ff      <= e_in;
   end

   assign exp_rsp.done  = done_ff;
   assign exp_rsp.value = e_ff;

endmodule

`default_nettype wire

// File: design/smax_div_unit.sv
// Bit-serial restoring divider: (dividend << 16) / divisor, one quotient bit
// per cycle, saturated to 16 bits. Depends on smax_pkg.
`default_nettype none

module smax_div_unit #(
   parameter int SUM_W = smax_pkg::EXP_W + $clog2(smax_pkg::MAX_CLASSES_DEFAULT)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  smax_pkg::div_req_type div_req,
   input  logic [SUM_W-1:0]      divisor,
   output smax_pkg::div_rsp_type div_rsp
);

   localparam int QUOT_BITS = smax_pkg::QUOT_BITS;
   localparam int CNT_W     = $clog2(QUOT_BITS);
   localparam int PROB_W    = smax_pkg::PROB_W;

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [SUM_W-1:0]     rem_ff;
   logic [QUOT_BITS-1:0] num_ff;
   logic [QUOT_BITS-1:0] quot_ff;

   logic [SUM_W:0] trial;
   logic [SUM_W:0] diff;
   logic           qbit;

   // Trial subtraction for the current quotient bit
   always_comb begin
      trial = {rem_ff, num_ff[QUOT_BITS-1]};
      diff  = trial - {1'b0, divisor};
      qbit  = (trial >= {1'b0, divisor});
   end

   // Control: run for one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUOT_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Remainder, numerator and quotient shift registers
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff  <= SUM_W'(div_req.dividend >> 1);
         num_ff  <= {div_req.dividend[0], {(QUOT_BITS - 1){1'b0}}};
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= qbit ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
         num_ff  <= num_ff << 1;
         quot_ff <= {quot_ff[QUOT_BITS-2:0], qbit};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff[QUOT_BITS-1] ? {PROB_W{1'b1}} : quot_ff[PROB_W-1:0];

endmodule

`default_nettype wire

// File: design/softmax_argmax_classifier_head_core.sv
// Softmax classifier head with argmax: logit store, exponent pass, division pass.
// Depends on smax_pkg, smax_ram, smax_exp_unit, smax_div_unit and the macro header.
//
// Usage:
//  - Request channel (req_valid/req_ready, req_logit): one signed Q8.8 logit per
//    request, taken one per cycle while the block is loading a vector.
//  - The vector ends when the number loaded reaches class_count (0 acts as 1,
//    values above MAX_CLASSES act as MAX_CLASSES). Requests are then refused
//    until the last result of the vector has moved into the output register.
//  - Response channel (rsp_valid/rsp_ready): one result per class, in class
//    order, each with the probability (Q0.16, saturated), the argmax class
//    (first index on ties) and last on the final class.
//  - Exponent pass: a term below the cutoff is zero; others run the bit-serial multiply.
//  - Division pass: each class runs the 17-step serial divider.
//  - The first result of a vector follows the exponent pass over it and one division,
//    each later one a further division while the receiver keeps up; a stalled receiver
//    holds the result in the output register and the next quotient waits in the divider.
//  - csr_wr_en/csr_wr_data write class_count at once; write it only when idle.
//  - Reset (synchronous) sets class_count to 11 and empties the vector.
`default_nettype none
`include "softmax_argmax_classifier_head_core_macros.svh"

module softmax_argmax_classifier_head_core #(
   parameter int MAX_CLASSES     = smax_pkg::MAX_CLASSES_DEFAULT,
   parameter int EXP_TABLE_DEPTH = smax_pkg::EXP_TABLE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [smax_pkg::LOGIT_W-1:0] req_logit,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [smax_pkg::CLASS_OUT_W-1:0]   rsp_class_index,
   output logic [smax_pkg::PROB_W-1:0]        rsp_probability,
   output logic [smax_pkg::CLASS_OUT_W-1:0]   rsp_best_class,
   output logic                               rsp_last,
   input  logic                               csr_wr_en,
   input  logic [smax_pkg::CSR_W-1:0]         csr_wr_data
);

   localparam int CLS_W       = $clog2(MAX_CLASSES);
   localparam int CNT_W       = $clog2(MAX_CLASSES + 1);
   localparam int LOGIT_W     = smax_pkg::LOGIT_W;
   localparam int EXP_W       = smax_pkg::EXP_W;
   localparam int PROB_W      = smax_pkg::PROB_W;
   localparam int CLASS_OUT_W = smax_pkg::CLASS_OUT_W;
   localparam int SUM_W       = EXP_W + CLS_W;

   smax_pkg::ctl_state_type state_ff, state_in;

   logic [smax_pkg::CSR_W-1:0] class_count_ff;
   logic [CNT_W-1:0]           load_cnt_ff, load_cnt_in;
   logic signed [LOGIT_W-1:0]  running_max_ff, running_max_in;
   logic [CLS_W-1:0]           best_ff, best_in;
   logic [CNT_W-1:0]           vec_len_ff, vec_len_in;
   logic [CLS_W-1:0]           cls_ptr_ff, cls_ptr_in;
   logic [SUM_W-1:0]           exp_sum_ff, exp_sum_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CLASS_OUT_W-1:0] rsp_class_index_ff, rsp_class_index_in;
   logic [PROB_W-1:0]      rsp_probability_ff, rsp_probability_in;
   logic [CLASS_OUT_W-1:0] rsp_best_class_ff, rsp_best_class_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                  req_fire;
   logic [CNT_W-1:0]      eff_count;
   logic [CNT_W-1:0]      load_next;
   logic [CNT_W-1:0]      ptr_next;
   logic                  ptr_last;
   logic                  emit_fire;

   logic                  logit_wr_en;
   logic [LOGIT_W-1:0]    logit_rd;
   logic                  exp_wr_en;
   logic [EXP_W-1:0]      exp_rd;

   smax_pkg::exp_req_type exp_req;
   smax_pkg::exp_rsp_type exp_rsp;
   smax_pkg::div_req_type div_req;
   smax_pkg::div_rsp_type div_rsp;

   // Logit store, written while loading, read during the exponent pass
   smax_ram #(
      .WIDTH (LOGIT_W),
      .DEPTH (MAX_CLASSES)
   ) u_logit_ram (
      .clock   (clock),
      .wr_en   (logit_wr_en),
      .wr_addr (load_cnt_ff[CLS_W-1:0]),
      .wr_data (req_logit),
      .rd_addr (cls_ptr_ff),
      .rd_data (logit_rd)
   );

   // Exponent store, written in the exponent pass, read in the division pass
   smax_ram #(
      .WIDTH (EXP_W),
      .DEPTH (MAX_CLASSES)
   ) u_exp_ram (
      .clock   (clock),
      .wr_en   (exp_wr_en),
      .wr_addr (cls_ptr_ff),
      .wr_data (exp_rsp.value),
      .rd_addr (cls_ptr_ff),
      .rd_data (exp_rd)
   );

   smax_exp_unit #(
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_exp_unit (
      .clock   (clock),
      .reset   (reset),
      .exp_req (exp_req),
      .exp_rsp (exp_rsp)
   );

   smax_div_unit #(
      .SUM_W (SUM_W)
   ) u_div_unit (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .divisor (exp_sum_ff),
      .div_rsp (div_rsp)
   );

   // Effective class count and pointer helpers
   always_comb begin
      if (class_count_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (32'(class_count_ff) > MAX_CLASSES) begin
         eff_count = CNT_W'(MAX_CLASSES);
      end else begin
         eff_count = CNT_W'(class_count_ff);
      end
      load_next = load_cnt_ff + 1'b1;
      ptr_next  = CNT_W'(cls_ptr_ff) + 1'b1;
      ptr_last  = (ptr_next == vec_len_ff);
      req_fire  = req_valid && req_ready;
      emit_fire = (state_ff == smax_pkg::CTL_EMIT) && (!rsp_valid_ff || rsp_ready);
   end

   // Sequencer: next state and outputs
   always_comb begin
      state_in           = state_ff;
      load_cnt_in        = load_cnt_ff;
      running_max_in     = running_max_ff;
      best_in            = best_ff;
      vec_len_in         = vec_len_ff;
      cls_ptr_in         = cls_ptr_ff;
      exp_sum_in         = exp_sum_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_class_index_in = rsp_class_index_ff;
      rsp_probability_in = rsp_probability_ff;
      rsp_best_class_in  = rsp_best_class_ff;
      rsp_last_in        = rsp_last_ff;
      req_ready          = (state_ff == smax_pkg::CTL_LOAD);
      logit_wr_en        = 1'b0;
      exp_wr_en          = 1'b0;
      exp_req.start      = 1'b0;
      exp_req.diff       = $signed({logit_rd[LOGIT_W-1], logit_rd})
                           - $signed({running_max_ff[LOGIT_W-1], running_max_ff});
      div_req.start      = 1'b0;
      div_req.dividend   = exp_rd;
      case (state_ff)
         smax_pkg::CTL_LOAD: begin
            if (req_fire) begin
               // store the logit and track the first maximum
               logit_wr_en = 1'b1;
               if ((load_cnt_ff == '0) || (req_logit > running_max_ff)) begin
                  running_max_in = req_logit;
                  best_in        = load_cnt_ff[CLS_W-1:0];
               end
               load_cnt_in = load_next;
               if (load_next >= eff_count) begin
                  vec_len_in  = load_next;
                  load_cnt_in = '0;
                  cls_ptr_in  = '0;
                  exp_sum_in  = '0;
                  state_in    = smax_pkg::CTL_EXP_READ;
               end
            end
         end
         smax_pkg::CTL_EXP_READ: begin
            state_in = smax_pkg::CTL_EXP_START;
         end
         smax_pkg::CTL_EXP_START: begin
            exp_req.start = 1'b1;
            state_in      = smax_pkg::CTL_EXP_WAIT;
         end
         smax_pkg::CTL_EXP_WAIT: begin
            if (exp_rsp.done) begin
               // keep the term and accumulate the sum
               exp_wr_en  = 1'b1;
               exp_sum_in = exp_sum_ff + SUM_W'(exp_rsp.value);
               if (ptr_last) begin
                  cls_ptr_in = '0;
                  state_in   = smax_pkg::CTL_DIV_READ;
               end else begin
                  cls_ptr_in = cls_ptr_ff + 1'b1;
                  state_in   = smax_pkg::CTL_EXP_READ;
               end
            end
         end
         smax_pkg::CTL_DIV_READ: begin
            state_in = smax_pkg::CTL_DIV_START;
         end
         smax_pkg::CTL_DIV_START: begin
            div_req.start = 1'b1;
            state_in      = smax_pkg::CTL_DIV_WAIT;
         end
         smax_pkg::CTL_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = smax_pkg::CTL_EMIT;
            end
         end
         smax_pkg::CTL_EMIT: begin
            // hand the result to the output register once it is free
            if (emit_fire) begin
               rsp_valid_in       = 1'b1;
               rsp_class_index_in = CLASS_OUT_W'(cls_ptr_ff);
               rsp_probability_in = div_rsp.quotient;
               rsp_best_class_in  = CLASS_OUT_W'(best_ff);
               rsp_last_in        = ptr_last;
               if (ptr_last) begin
                  cls_ptr_in = '0;
                  state_in   = smax_pkg::CTL_LOAD;
               end else begin
                  cls_ptr_in = cls_ptr_ff + 1'b1;
                  state_in   = smax_pkg::CTL_DIV_READ;
               end
            end
         end
         default: begin
            state_in = smax_pkg::CTL_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= smax_pkg::CTL_LOAD;
         class_count_ff <= smax_pkg::CLASS_COUNT_RESET;
         load_cnt_ff    <= '0;
         running_max_ff <= '0;
         best_ff        <= '0;
         vec_len_ff     <= '0;
         cls_ptr_ff     <= '0;
         exp_sum_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         load_cnt_ff    <= load_cnt_in;
         running_max_ff <= running_max_in;
         best_ff        <= best_in;
         vec_len_ff     <= vec_len_in;
         cls_ptr_ff     <= cls_ptr_in;
         exp_sum_ff     <= exp_sum_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            class_count_ff <= csr_wr_data;
         end
      end
   end

   // Response payload registers
   always_ff @(posedge clock) begin
      rsp_class_index_ff <= rsp_class_index_in;
      rsp_probability_ff <= rsp_probability_in;
      rsp_best_class_ff  <= rsp_best_class_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_class_index = rsp_class_index_ff;
   assign rsp_probability = rsp_probability_ff;
   assign rsp_best_class  = rsp_best_class_ff;
   assign rsp_last        = rsp_last_ff;

   // Checks on the sequencer
   `SMAX_ASSERT_SAME(a_exp_done_in_wait, clock, reset, exp_rsp.done, state_ff == smax_pkg::CTL_EXP_WAIT)
   `SMAX_ASSERT_SAME(a_div_done_in_wait, clock, reset, div_rsp.done, state_ff == smax_pkg::CTL_DIV_WAIT)
   `SMAX_ASSERT_SAME(a_sum_nonzero, clock, reset, state_ff == smax_pkg::CTL_DIV_START, exp_sum_ff != '0)
   `SMAX_ASSERT_NEXT(a_last_to_load, clock, reset, emit_fire && ptr_last, (state_ff == smax_pkg::CTL_LOAD) && rsp_last_ff)

endmodule

`default_nettype wire
